// ===== sv/srg_pkg.sv =====
`default_nettype none

package srg_pkg;

  localparam int RUN_CAPACITY = 64;
  localparam int DATA_W       = 32;
  localparam int CNT_W        = $clog2(RUN_CAPACITY + 1);
  localparam int IDX_W        = $clog2(RUN_CAPACITY);
  localparam int RL_W         = 7;

  // run controller states
  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_in;
    logic                     end_of_data;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_out;
    logic                     last_in_run;
    logic                     last_run;
  } out_item_t;

  // control broadcast from the run controller to every cell
  typedef struct packed {
    logic             insert;
    logic             drain;
    logic [CNT_W-1:0] fill;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/srg_cell.sv =====
`default_nettype none

module srg_cell import srg_pkg::*; (
  input  wire logic                     clk,
  input  wire cell_ctl_t                ctl,
  input  wire logic [IDX_W-1:0]         idx,
  input  wire logic signed [DATA_W-1:0] new_value,
  input  wire logic signed [DATA_W-1:0] left_value,
  input  wire logic                     left_gt,
  input  wire logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0]      value,
  output logic                          gt
);

  logic occupied;

  // an empty cell counts as larger than any value
  assign occupied = {1'b0, idx} < ctl.fill;
  assign gt       = !occupied || (new_value < value);

  // insert: shift right where the left neighbor also moves, else take the new value
  // drain: take the right neighbor's value
  always_ff @(posedge clk) begin
    if (ctl.insert && gt) begin
      value <= left_gt ? left_value : new_value;
    end else if (ctl.drain) begin
      value <= right_value;
    end
  end

endmodule

`default_nettype wire

// ===== sv/srg_ctrl.sv =====
`default_nettype none

module srg_ctrl import srg_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [RL_W-1:0] cfg_data,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            end_of_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 last_in_run,
  output logic                 last_run,
  output cell_ctl_t            ctl
);

  localparam logic [RL_W-1:0] CapLen = RL_W'(RUN_CAPACITY);

  logic             state;
  logic [CNT_W-1:0] fill;
  logic [RL_W-1:0]  run_length;
  logic [RL_W-1:0]  eff_len;
  logic [RL_W-1:0]  fill_next;
  logic             in_fire;
  logic             out_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_FILL);
  assign out_valid = (state == ST_DRAIN);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // clamp the run length to 1..capacity
  always_comb begin
    if (run_length == '0) begin
      eff_len = RL_W'(1);
    end else if (run_length > CapLen) begin
      eff_len = CapLen;
    end else begin
      eff_len = run_length;
    end
  end

  assign fill_next   = RL_W'(fill) + RL_W'(1);
  assign last_in_run = (fill == CNT_W'(1));

  assign ctl.insert = in_fire;
  assign ctl.drain  = out_fire;
  assign ctl.fill   = fill;

  // hold the run length register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_length <= RL_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      run_length <= cfg_data;
    end
  end

  // count values in, switch to drain at a full run or end of data, count values out
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_FILL;
      fill     <= '0;
      last_run <= 1'b0;
    end else begin
      unique case (state)
        ST_FILL: begin
          if (in_fire) begin
            fill <= CNT_W'(fill_next);
            if (fill_next >= eff_len || end_of_data) begin
              state    <= ST_DRAIN;
              last_run <= end_of_data;
            end
          end
        end
        ST_DRAIN: begin
          if (out_fire) begin
            fill <= fill - CNT_W'(1);
            if (last_in_run) begin
              state <= ST_FILL;
            end
          end
        end
        default: begin
          state <= ST_FILL;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/sorted_run_generator_core.sv =====
// Sorted run generator: values enter on in_item and are kept in ascending
// order in a row of 64 cells as they arrive, one value per cycle while a
// run fills. When the run reaches run_length values (0 acts as 1, values
// above 64 act as 64) or an item carries end_of_data, the block stops
// taking items and drains the run from the head cell, smallest first, one
// value per cycle while out_ready is high; last_in_run marks the final
// value, last_run marks every value of a run closed by end_of_data. No
// item is taken while a run drains; inserts are broadcast to the whole
// cell row and values leave by a single output tap at its head. Write
// run_length only while no run is pending. Reset: synchronous, active
// high, run_length returns to 64.
`default_nettype none

module sorted_run_generator_core import srg_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [RL_W-1:0] cfg_data,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire in_item_t        in_item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output out_item_t            out_item
);

  cell_ctl_t                ctl;
  logic                     last_in_run;
  logic                     last_run;
  logic signed [DATA_W-1:0] cell_value [RUN_CAPACITY];
  logic                     cell_gt    [RUN_CAPACITY];

  srg_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .end_of_data (in_item.end_of_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .last_in_run (last_in_run),
    .last_run    (last_run),
    .ctl         (ctl)
  );

  // build the cell row; ends tie off to safe neighbors
  for (genvar i = 0; i < RUN_CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_value;
    logic                     left_gt;
    logic signed [DATA_W-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_value = in_item.data_in;
      assign left_gt    = 1'b0;
    end else begin : g_mid
      assign left_value = cell_value[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == RUN_CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_body
      assign right_value = cell_value[i+1];
    end

    srg_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .idx         (IDX_W'(i)),
      .new_value   (in_item.data_in),
      .left_value  (left_value),
      .left_gt     (left_gt),
      .right_value (right_value),
      .value       (cell_value[i]),
      .gt          (cell_gt[i])
    );
  end

  // present the head cell
  assign out_item.sorted_out  = cell_value[0];
  assign out_item.last_in_run = last_in_run;
  assign out_item.last_run    = last_run;

endmodule

`default_nettype wire

// ===== sv/srg_checker.sv =====
`default_nettype none

module srg_checker import srg_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  // never take an item while a run drains
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready && out_valid))
    else $error("item taken during drain");

  // a run keeps draining until its last value
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_item.last_in_run |=> out_valid)
    else $error("run drain stopped early");

  // the run ends after its last value
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_item.last_in_run |=> !out_valid)
    else $error("output after last value of run");

  // values of one run come out ascending
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_item.last_in_run |=>
      (out_item.sorted_out >= $past(out_item.sorted_out)))
    else $error("run not ascending");

  // last_run holds across a run
  a_last_run_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_item.last_in_run |=>
      (out_item.last_run == $past(out_item.last_run)))
    else $error("last_run changed within a run");

endmodule

bind sorted_run_generator_core srg_checker u_srg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

// ===== bench/sorted_run_checker.sv =====
`timescale 1ns / 100ps

module sorted_run_checker import srg_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [RL_W-1:0] cfg_data,
  input  logic            in_valid,
  input  logic            in_ready,
  input  in_item_t        in_item,
  input  logic            out_valid,
  input  logic            out_ready,
  input  out_item_t       out_item,
  output int              mismatches,
  output int              pending
);

  // values gathered for the run being filled
  logic signed [DATA_W-1:0] run_values [RUN_CAPACITY];
  int                       held;
  logic [RL_W-1:0]          run_length;
  // sorted values still owed by the block, oldest first
  out_item_t                sorted_q [$];
  int                       result_no;

  // effective run length: zero acts as one, saturate at capacity
  function automatic int run_limit(input logic [RL_W-1:0] len);
    if (len == 0) return 1;
    if (len > RUN_CAPACITY) return RUN_CAPACITY;
    return int'(len);
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t: result %0d: %s got %0h, expected %0h", $time, result_no, what, got, want);
    mismatches++;
  endtask

  // sort the held values ascending and queue one result per value
  task automatic close_run(input logic eod);
    logic signed [DATA_W-1:0] v;
    int                       j;
    out_item_t                res;
    for (int i = 1; i < held; i++) begin
      v = run_values[i];
      j = i;
      while (j > 0 && v < run_values[j-1]) begin
        run_values[j] = run_values[j-1];
        j--;
      end
      run_values[j] = v;
    end
    for (int k = 0; k < held; k++) begin
      res.sorted_out  = run_values[k];
      res.last_in_run = (k == held - 1);
      res.last_run    = eod;
      sorted_q = {sorted_q, res};
    end
    held = 0;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      held       = 0;
      run_length = 7'd64;
      sorted_q.delete();
      mismatches = 0;
      result_no  = 0;
    end else begin
      // track the run length register
      if (cfg_valid && cfg_ready)
        run_length = cfg_data;
      // compare each delivered item with the oldest expectation
      if (out_valid && out_ready) begin
        if (sorted_q.size() == 0) begin
          report_mismatch("unexpected item, sorted_out", out_item.sorted_out, '0);
        end else begin
          want = sorted_q.pop_front();
          if (out_item.sorted_out !== want.sorted_out)
            report_mismatch("sorted_out", out_item.sorted_out, want.sorted_out);
          if (out_item.last_in_run !== want.last_in_run)
            report_mismatch("last_in_run", 32'(out_item.last_in_run), 32'(want.last_in_run));
          if (out_item.last_run !== want.last_run)
            report_mismatch("last_run", 32'(out_item.last_run), 32'(want.last_run));
        end
        result_no++;
      end
      // collect the accepted value, close the run when full or at end of data
      if (in_valid && in_ready) begin
        if (held >= RUN_CAPACITY) held = 0;
        run_values[held] = in_item.data_in;
        held++;
        if (held >= run_limit(run_length) || in_item.end_of_data)
          close_run(in_item.end_of_data);
      end
    end
    pending = sorted_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench import srg_pkg::*;;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int NUM_PHASES     = 8;

  logic            clk;
  logic            rst;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [RL_W-1:0] cfg_data;
  logic            in_valid;
  logic            in_ready;
  in_item_t        in_item;
  logic            out_valid;
  logic            out_ready;
  out_item_t       out_item;
  int              mismatches;
  int              pending;

  // sender burst state and receiver hold request
  int              burst_left = 0;
  bit              steady     = 1'b0;
  bit              hold_req   = 1'b0;
  int              quiet_cycles = 0;

  // random phases: run length setting and number of items
  int phase_len   [NUM_PHASES] = '{3, 64, 1, 127, 7, 0, 2, -1};
  int phase_items [NUM_PHASES] = '{25, 66, 15, 66, 30, 10, 15, 25};

  sorted_run_generator_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  sorted_run_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** sorted_run_generator_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: stall at a rate that changes per epoch, long hold once on request
  initial begin
    int unsigned stall_pct;
    int unsigned epoch;
    bit          hold_done;
    stall_pct = 0;
    epoch     = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (epoch == 0) begin
          epoch = $urandom_range(20, 80);
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 30;
            3:       stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        epoch--;
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3:    return $signed(32'($urandom_range(0, 8))) - 32'sd4;
      default: return $signed(32'($urandom));
    endcase
  endfunction

  // offer one item, idling between bursts; hold valid until accepted
  task automatic send_value(input logic signed [DATA_W-1:0] v, input logic eod);
    int gap;
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_item  <= '{data_in: v, end_of_data: eod};
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every expected item has come out
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_run_length(input logic [RL_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [RL_W-1:0] len;
    logic            eod;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, negatives and duplicates closed by end of data at reset length
    send_value(32'sh8000_0000, 1'b0);
    send_value(32'sh7fff_ffff, 1'b0);
    send_value(32'sd0, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(32'sd1, 1'b0);
    send_value(32'sd5, 1'b0);
    send_value(32'sd5, 1'b0);
    send_value(-32'sd5, 1'b1);
    settle();

    // one value per run
    write_run_length(7'd1);
    send_value(32'sd42, 1'b0);
    send_value(-32'sd42, 1'b1);
    settle();

    // zero length acts as one
    write_run_length(7'd0);
    send_value(32'sd7, 1'b0);
    send_value(32'sd8, 1'b0);
    settle();

    // lower the length while a run is partly filled
    write_run_length(7'd64);
    send_value(32'sd9, 1'b0);
    send_value(-32'sd3, 1'b0);
    send_value(32'sd100, 1'b0);
    send_value(-32'sd100, 1'b0);
    send_value(32'sd0, 1'b0);
    settle();
    write_run_length(7'd3);
    send_value(32'sd50, 1'b0);
    settle();

    // full short run, then a lone end-of-data value
    write_run_length(7'd2);
    send_value(32'sh7fff_ffff, 1'b0);
    send_value(32'sh8000_0000, 1'b0);
    send_value(32'sd3, 1'b1);
    settle();

    // random phases, each closed by end of data before the next write
    for (int p = 0; p < NUM_PHASES; p++) begin
      len = (phase_len[p] < 0) ? RL_W'($urandom_range(0, 127)) : RL_W'(phase_len[p]);
      write_run_length(len);
      steady = (p == 4);
      // stall the output while the sender keeps offering a full run
      if (p == 1) hold_req = 1'b1;
      for (int k = 0; k < phase_items[p]; k++) begin
        eod = (k == phase_items[p] - 1) || (len < 64 && $urandom_range(0, 24) == 0);
        send_value(pick_value(), eod);
      end
      settle();
    end
    steady = 1'b0;

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("** sorted_run_generator_core: PASSED **");
    else
      $display("** sorted_run_generator_core: FAILED **");
    $finish;
  end

endmodule
